### hdl/spm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg: shared types and constants for the sensor poll master
// States, register indexes, expected answer lengths and the type size table.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int MAX_POINTS_DEF = 16;

    localparam logic [7:0] LEN_VERSION   = 8'd6;
    localparam logic [7:0] LEN_BOARD     = 8'd28;
    localparam logic [7:0] LEN_DESC      = 8'd20;
    localparam logic [7:0] LEN_VALUE_HDR = 8'd6;
    localparam logic [15:0] TIMEOUT_RESET = 16'd20;
    localparam logic [2:0] MAX_TRIES = 3'd3;

    typedef enum logic [3:0] {
        ST_INIT       = 4'd0,
        ST_SEND_VER   = 4'd1,
        ST_WAIT_VER   = 4'd2,
        ST_PROC_VER   = 4'd3,
        ST_SEND_BRD   = 4'd4,
        ST_WAIT_BRD   = 4'd5,
        ST_PROC_BRD   = 4'd6,
        ST_SEND_DESC  = 4'd7,
        ST_WAIT_DESC  = 4'd8,
        ST_PROC_DESC  = 4'd9,
        ST_MAKE_SCHED = 4'd10,
        ST_RUN_SCH    = 4'd11,
        ST_SEND_VAL   = 4'd12,
        ST_WAIT_VAL   = 4'd13,
        ST_PROC_VAL   = 4'd14,
        ST_BAD        = 4'd15
    } spm_state_t;

    // sequencer phases inside one tick
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CLEAR,
        PH_BUILD,
        PH_RUN,
        PH_LOOKUP,
        PH_DONE
    } spm_phase_t;

    typedef enum logic [2:0] {
        REG_VER_ADDR  = 3'd0,
        REG_BRD_ADDR  = 3'd1,
        REG_DESC_BASE = 3'd2,
        REG_DATA_BASE = 3'd3,
        REG_EXP_VER   = 3'd4,
        REG_OK_STATUS = 3'd5,
        REG_TIMEOUT   = 3'd6,
        REG_NONE      = 3'd7
    } spm_reg_t;

    typedef struct packed {
        logic [7:0]  ver_addr;
        logic [7:0]  brd_addr;
        logic [7:0]  desc_base;
        logic [7:0]  data_base;
        logic [7:0]  exp_ver;
        logic [7:0]  ok_status;
        logic [15:0] timeout;
    } spm_cfg_t;

    function automatic logic [7:0] type_size(input logic [3:0] t);
        case (t)
            4'd0, 4'd1: type_size = 8'd1;
            4'd2, 4'd3: type_size = 8'd2;
            4'd4, 4'd5, 4'd8: type_size = 8'd4;
            4'd6, 4'd7, 4'd9: type_size = 8'd8;
            default: type_size = 8'd0;
        endcase
    endfunction

endpackage

### hdl/spm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_regs: APB configuration registers
// Seven word-addressed registers, reads return the stored value.
// ----------------------------------------------------------------------------
module spm_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output spm_pkg::spm_cfg_t    cfg
);
    import spm_pkg::*;

    spm_cfg_t cfg_reg;
    spm_reg_t idx;

    assign pready = 1'b1;
    assign cfg    = cfg_reg;
    assign idx    = spm_reg_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, TIMEOUT_RESET};
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_VER_ADDR:  cfg_reg.ver_addr  <= pwdata[7:0];
                REG_BRD_ADDR:  cfg_reg.brd_addr  <= pwdata[7:0];
                REG_DESC_BASE: cfg_reg.desc_base <= pwdata[7:0];
                REG_DATA_BASE: cfg_reg.data_base <= pwdata[7:0];
                REG_EXP_VER:   cfg_reg.exp_ver   <= pwdata[7:0];
                REG_OK_STATUS: cfg_reg.ok_status <= pwdata[7:0];
                REG_TIMEOUT:   cfg_reg.timeout   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_VER_ADDR:  prdata = {24'd0, cfg_reg.ver_addr};
            REG_BRD_ADDR:  prdata = {24'd0, cfg_reg.brd_addr};
            REG_DESC_BASE: prdata = {24'd0, cfg_reg.desc_base};
            REG_DATA_BASE: prdata = {24'd0, cfg_reg.data_base};
            REG_EXP_VER:   prdata = {24'd0, cfg_reg.exp_ver};
            REG_OK_STATUS: prdata = {24'd0, cfg_reg.ok_status};
            REG_TIMEOUT:   prdata = {16'd0, cfg_reg.timeout};
            default:       prdata = 32'd0;
        endcase
    end
endmodule

### hdl/sensor_poll_master_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_poll_master_fsm: polling master for a sensor board
// Steps the protocol table once per tick transaction and reports one result.
// ----------------------------------------------------------------------------
//  channel   | ports    | moves
//  ----------+----------+-------------------------------------------
//  tick in   | s_*      | rx count, send status, decoded answer fields
//  result    | m_*      | state, request, rx clear, accepted value
//  config    | APB p*   | seven setup registers
//
// Plain states pass through the lookup phase; MAKE_SCHED, RUN_SCH and a restart
// walk the point tables one entry a cycle.
// Clear, build and countdown walks share one walk index; a single
// decrement/compare unit serves the countdown.
// A restart clears the tables. Reset is synchronous, active low. s_ready
// is low from acceptance until the result is registered; a result stalled by
// m_ready holds the next transaction in its last phase.
module sensor_poll_master_fsm #(
    parameter int MAX_POINTS = spm_pkg::MAX_POINTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_count,
    input  logic        s_send_ok,
    input  logic [7:0]  s_ans_len,
    input  logic [7:0]  s_ans_addr,
    input  logic [7:0]  s_ans_status,
    input  logic [7:0]  s_ans_version,
    input  logic [7:0]  s_ans_point_count,
    input  logic [3:0]  s_ans_point_type,
    input  logic        s_ans_readable,
    input  logic [31:0] s_ans_period,
    input  logic [63:0] s_ans_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_state_now,
    output logic        m_send_req,
    output logic [7:0]  m_req_addr,
    output logic        m_rx_clear,
    output logic        m_value_valid,
    output logic [3:0]  m_value_point,
    output logic [3:0]  m_value_type,
    output logic [63:0] m_value_data
);
    import spm_pkg::*;

    spm_cfg_t cfg;

    spm_regs u_regs (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    spm_core #(.MAX_POINTS(MAX_POINTS)) u_core (
        .aclk, .aresetn, .cfg,
        .s_valid, .s_ready, .s_rx_count, .s_send_ok, .s_ans_len, .s_ans_addr,
        .s_ans_status, .s_ans_version, .s_ans_point_count, .s_ans_point_type,
        .s_ans_readable, .s_ans_period, .s_ans_value,
        .m_valid, .m_ready, .m_state_now, .m_send_req, .m_req_addr,
        .m_rx_clear, .m_value_valid, .m_value_point, .m_value_type, .m_value_data
    );
endmodule

### hdl/spm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_core: protocol table and schedule sequencer
// Holds the point and schedule tables and walks them one entry a cycle.
// ----------------------------------------------------------------------------
module spm_core #(
    parameter int MAX_POINTS = spm_pkg::MAX_POINTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  spm_pkg::spm_cfg_t cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_count,
    input  logic        s_send_ok,
    input  logic [7:0]  s_ans_len,
    input  logic [7:0]  s_ans_addr,
    input  logic [7:0]  s_ans_status,
    input  logic [7:0]  s_ans_version,
    input  logic [7:0]  s_ans_point_count,
    input  logic [3:0]  s_ans_point_type,
    input  logic        s_ans_readable,
    input  logic [31:0] s_ans_period,
    input  logic [63:0] s_ans_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_state_now,
    output logic        m_send_req,
    output logic [7:0]  m_req_addr,
    output logic        m_rx_clear,
    output logic        m_value_valid,
    output logic [3:0]  m_value_point,
    output logic [3:0]  m_value_type,
    output logic [63:0] m_value_data
);
    import spm_pkg::*;

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] MAXP = CW'(MAX_POINTS);

    // tables, small: each a register array walked by one shared index
    logic [3:0]    ptype_mem  [MAX_POINTS];
    logic          pread_mem  [MAX_POINTS];
    logic [31:0]   pper_mem   [MAX_POINTS];
    logic [IW-1:0] spoint_mem [MAX_POINTS];
    logic [31:0]   sreload_mem[MAX_POINTS];
    logic [31:0]   scount_mem [MAX_POINTS];
    logic [IW-1:0] scan_mem   [MAX_POINTS];

    spm_state_t st_reg, st_next;
    spm_phase_t ph_reg, ph_next;
    logic [15:0] wait_reg;
    logic [7:0]  cursor_reg;
    logic [2:0]  retry_reg;
    logic [7:0]  bpoints_reg;
    logic [CW-1:0] sent_reg, scnt_reg;
    logic [CW-1:0] walk_reg;

    // captured tick
    logic [7:0]  rx_r, len_r, addr_r, status_r, ver_r, pcnt_r;
    logic [3:0]  ptype_r;
    logic        pread_r, sendok_r;
    logic [31:0] period_r;
    logic [63:0] value_r;

    logic        out_send, out_clr, out_vv;
    logic [7:0]  out_addr;
    logic [3:0]  out_vp, out_vt;
    logic        mvalid_reg;

    // shared lookup register (point/type of scan cursor)
    logic [IW-1:0] lk_point_reg;
    logic          lk_ok_reg;
    logic [3:0]    lk_type_reg;

    logic [IW-1:0] wi;
    assign wi = walk_reg[IW-1:0];

    assign s_ready = (ph_reg == PH_IDLE);
    assign m_valid = mvalid_reg;

    // wait logic
    logic [15:0] wait_inc;
    logic        w_ans, w_to, w_clr;
    always_comb begin
        wait_inc = wait_reg + 16'd1;
        w_ans = 1'b0; w_to = 1'b0; w_clr = 1'b0;
        if (wait_reg != 16'd0 && rx_r > 8'd3) begin
            w_ans = 1'b1; w_clr = 1'b1;
        end else if (wait_inc > cfg.timeout) begin
            if (rx_r != 8'd0) w_ans = 1'b1;
            else w_to = 1'b1;
        end
    end

    // shared countdown unit for the schedule walk
    logic [31:0] cnt_cur, cnt_dec;
    logic        cnt_exp;
    always_comb begin
        cnt_cur = scount_mem[wi];
        cnt_dec = (cnt_cur != 32'd0) ? cnt_cur - 32'd1 : 32'd0;
        cnt_exp = (cnt_dec == 32'd0);
    end

    logic desc_in_rng;
    assign desc_in_rng = (cursor_reg < 8'(MAX_POINTS));
    logic [7:0] desc_addr, val_addr, val_expect;
    assign desc_addr  = cfg.desc_base + cursor_reg;
    assign val_addr   = cfg.data_base + {{(8-IW){1'b0}}, lk_point_reg};
    assign val_expect = LEN_VALUE_HDR + (lk_ok_reg ? type_size(lk_type_reg) : 8'd0);

    // phase sequencer
    always_comb begin
        ph_next = ph_reg;
        case (ph_reg)
            PH_IDLE: if (s_valid) begin
                case (st_reg)
                    ST_INIT, ST_BAD: ph_next = PH_CLEAR;
                    ST_MAKE_SCHED:   ph_next = PH_BUILD;
                    ST_RUN_SCH:      ph_next = PH_RUN;
                    default:         ph_next = PH_LOOKUP;
                endcase
            end
            PH_CLEAR: if (walk_reg == MAXP - CW'(1)) ph_next = PH_DONE;
            PH_BUILD: if (walk_reg == MAXP - CW'(1)) ph_next = PH_DONE;
            PH_RUN:   if (walk_reg == MAXP - CW'(1)) ph_next = PH_DONE;
            PH_LOOKUP: ph_next = PH_DONE;
            PH_DONE:  ph_next = PH_IDLE;
            default:  ph_next = PH_IDLE;
        endcase
        // a stalled result holds the commit
        if (ph_reg == PH_DONE && mvalid_reg && !m_ready) ph_next = PH_DONE;
    end

    // next table state, evaluated in the lookup/done phase on captured fields
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_SEND_VER:  st_next = sendok_r ? ST_WAIT_VER : ST_INIT;
            ST_WAIT_VER:  st_next = w_ans ? ST_PROC_VER : w_to ? ST_INIT : ST_WAIT_VER;
            ST_PROC_VER:  st_next = (len_r == LEN_VERSION && status_r == cfg.ok_status &&
                                     ver_r == cfg.exp_ver) ? ST_SEND_BRD : ST_INIT;
            ST_SEND_BRD:  st_next = sendok_r ? ST_WAIT_BRD : ST_INIT;
            ST_WAIT_BRD:  st_next = w_ans ? ST_PROC_BRD : w_to ? ST_INIT : ST_WAIT_BRD;
            ST_PROC_BRD:  st_next = (len_r == LEN_BOARD && pcnt_r != 8'd0 &&
                                     {1'b0, pcnt_r} <= 9'(MAX_POINTS)) ? ST_SEND_DESC : ST_INIT;
            ST_SEND_DESC: begin
                if (cursor_reg >= bpoints_reg) st_next = ST_MAKE_SCHED;
                else if (retry_reg + 3'd1 > MAX_TRIES) st_next = ST_INIT;
                else st_next = sendok_r ? ST_WAIT_DESC : ST_INIT;
            end
            ST_WAIT_DESC: st_next = w_ans ? ST_PROC_DESC : w_to ? ST_SEND_DESC : ST_WAIT_DESC;
            ST_PROC_DESC: st_next = (len_r != LEN_DESC || addr_r != desc_addr) ?
                                    ST_INIT : ST_SEND_DESC;
            ST_MAKE_SCHED: st_next = ST_RUN_SCH;
            ST_RUN_SCH:   st_next = (scnt_reg != '0) ? ST_SEND_VAL : ST_RUN_SCH;
            ST_SEND_VAL: begin
                if (cursor_reg >= {{(8-CW){1'b0}}, scnt_reg}) st_next = ST_RUN_SCH;
                else if (retry_reg + 3'd1 > MAX_TRIES) st_next = ST_INIT;
                else st_next = sendok_r ? ST_WAIT_VAL : ST_INIT;
            end
            ST_WAIT_VAL:  st_next = w_ans ? ST_PROC_VAL : w_to ? ST_SEND_VAL : ST_WAIT_VAL;
            ST_PROC_VAL:  st_next = ST_SEND_VAL;
            default:      st_next = ST_SEND_VER;
        endcase
    end

    // result outputs
    logic val_good;
    assign val_good = (len_r == val_expect) && (addr_r == val_addr);
    always_comb begin
        out_send = 1'b0; out_addr = 8'd0; out_clr = 1'b0;
        out_vv = 1'b0; out_vp = 4'd0; out_vt = 4'd0;
        case (st_reg)
            ST_SEND_VER: begin out_send = 1'b1; out_addr = cfg.ver_addr; end
            ST_SEND_BRD: begin out_send = 1'b1; out_addr = cfg.brd_addr; end
            ST_SEND_DESC: if (cursor_reg < bpoints_reg && retry_reg + 3'd1 <= MAX_TRIES) begin
                out_send = 1'b1; out_addr = desc_addr;
            end
            ST_SEND_VAL: if (cursor_reg < {{(8-CW){1'b0}}, scnt_reg} &&
                             retry_reg + 3'd1 <= MAX_TRIES) begin
                out_send = 1'b1; out_addr = val_addr;
            end
            ST_WAIT_VER, ST_WAIT_BRD, ST_WAIT_DESC, ST_WAIT_VAL: out_clr = w_clr;
            ST_PROC_VAL: if (val_good) begin
                out_vv = 1'b1;
                out_vp = 4'({{(8-IW){1'b0}}, lk_point_reg});
                out_vt = lk_type_reg;
            end
            ST_INIT, ST_BAD: out_clr = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_IDLE;
            st_reg <= ST_INIT;
            wait_reg <= '0; cursor_reg <= '0; retry_reg <= '0; bpoints_reg <= '0;
            sent_reg <= '0; scnt_reg <= '0; walk_reg <= '0;
            mvalid_reg <= 1'b0;
            for (int i = 0; i < MAX_POINTS; i++) begin
                pread_mem[i] <= 1'b0; pper_mem[i] <= '0; ptype_mem[i] <= '0;
                scount_mem[i] <= '0; sreload_mem[i] <= '0; spoint_mem[i] <= '0;
                scan_mem[i] <= '0;
            end
        end else begin
            ph_reg <= ph_next;
            if (mvalid_reg && m_ready && ph_reg != PH_DONE) mvalid_reg <= 1'b0;
            case (ph_reg)
                PH_IDLE: begin
                    walk_reg <= '0;
                    if (s_valid) begin
                        rx_r <= s_rx_count; sendok_r <= s_send_ok; len_r <= s_ans_len;
                        addr_r <= s_ans_addr; status_r <= s_ans_status;
                        ver_r <= s_ans_version; pcnt_r <= s_ans_point_count;
                        ptype_r <= s_ans_point_type; pread_r <= s_ans_readable;
                        period_r <= s_ans_period; value_r <= s_ans_value;
                        if (st_reg == ST_MAKE_SCHED) sent_reg <= '0;
                        if (st_reg == ST_RUN_SCH) scnt_reg <= '0;
                    end
                end
                PH_CLEAR: begin
                    pread_mem[wi] <= 1'b0; pper_mem[wi] <= '0; ptype_mem[wi] <= '0;
                    scount_mem[wi] <= '0; sreload_mem[wi] <= '0; spoint_mem[wi] <= '0;
                    scan_mem[wi] <= '0;
                    walk_reg <= walk_reg + CW'(1);
                end
                PH_BUILD: begin
                    if ({{(8-CW){1'b0}}, walk_reg} < bpoints_reg && pread_mem[wi] &&
                        pper_mem[wi] != 32'd0) begin
                        spoint_mem[sent_reg[IW-1:0]]  <= wi;
                        scount_mem[sent_reg[IW-1:0]]  <= pper_mem[wi];
                        sreload_mem[sent_reg[IW-1:0]] <= pper_mem[wi];
                        sent_reg <= sent_reg + CW'(1);
                    end
                    walk_reg <= walk_reg + CW'(1);
                end
                PH_RUN: begin
                    if (walk_reg < sent_reg) begin
                        if (cnt_exp) begin
                            scan_mem[scnt_reg[IW-1:0]] <= spoint_mem[wi];
                            scnt_reg <= scnt_reg + CW'(1);
                            scount_mem[wi] <= sreload_mem[wi];
                        end else begin
                            scount_mem[wi] <= cnt_dec;
                        end
                    end
                    walk_reg <= walk_reg + CW'(1);
                end
                PH_LOOKUP: begin
                    lk_point_reg <= (cursor_reg < 8'(MAX_POINTS)) ?
                                    scan_mem[cursor_reg[IW-1:0]] : '0;
                    lk_type_reg  <= (cursor_reg < 8'(MAX_POINTS)) ?
                                    ptype_mem[scan_mem[cursor_reg[IW-1:0]]] : 4'd0;
                    lk_ok_reg    <= (cursor_reg < 8'(MAX_POINTS)) &&
                                    (ptype_mem[scan_mem[cursor_reg[IW-1:0]]] < 4'd10);
                end
                PH_DONE: if (!mvalid_reg || m_ready) begin
                    // commit tick
                    mvalid_reg <= 1'b1;
                    st_reg <= st_next;
                    m_state_now <= 4'(st_next);
                    m_send_req <= out_send; m_req_addr <= out_addr; m_rx_clear <= out_clr;
                    m_value_valid <= out_vv; m_value_point <= out_vp;
                    m_value_type <= out_vt;
                    m_value_data <= out_vv ? value_r : 64'd0;
                    case (st_reg)
                        ST_INIT, ST_BAD: begin
                            wait_reg <= '0; cursor_reg <= '0; retry_reg <= '0;
                            bpoints_reg <= '0; sent_reg <= '0; scnt_reg <= '0;
                        end
                        ST_SEND_VER, ST_SEND_BRD: wait_reg <= '0;
                        ST_WAIT_VER, ST_WAIT_BRD, ST_WAIT_DESC, ST_WAIT_VAL:
                            if (!(wait_reg != 16'd0 && rx_r > 8'd3)) wait_reg <= wait_inc;
                        ST_PROC_BRD: begin
                            cursor_reg <= '0;
                            if (len_r == LEN_BOARD) begin
                                bpoints_reg <= pcnt_r;
                                if (st_next == ST_SEND_DESC) retry_reg <= '0;
                            end
                        end
                        ST_SEND_DESC: if (cursor_reg < bpoints_reg) begin
                            retry_reg <= retry_reg + 3'd1;
                            if (retry_reg + 3'd1 <= MAX_TRIES) wait_reg <= '0;
                        end
                        ST_PROC_DESC: if (st_next == ST_SEND_DESC) begin
                            if (desc_in_rng) begin
                                ptype_mem[cursor_reg[IW-1:0]] <= ptype_r;
                                pread_mem[cursor_reg[IW-1:0]] <= pread_r;
                                pper_mem[cursor_reg[IW-1:0]]  <= period_r;
                            end
                            retry_reg <= '0;
                            cursor_reg <= cursor_reg + 8'd1;
                        end
                        ST_RUN_SCH: if (scnt_reg != '0) begin
                            cursor_reg <= '0; retry_reg <= '0;
                        end
                        ST_SEND_VAL: if (cursor_reg < {{(8-CW){1'b0}}, scnt_reg}) begin
                            retry_reg <= retry_reg + 3'd1;
                            if (retry_reg + 3'd1 <= MAX_TRIES) wait_reg <= '0;
                        end
                        ST_PROC_VAL: if (val_good) begin
                            retry_reg <= '0;
                            cursor_reg <= cursor_reg + 8'd1;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end
endmodule

### hdl/spm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_checker: port-level checks for the sensor poll master
// Handshake and result consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module spm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_state_now,
    input logic        m_send_req,
    input logic [7:0]  m_req_addr,
    input logic        m_value_valid,
    input logic [63:0] m_value_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_state_now))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a tick while busy");
    a_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_send_req |-> m_req_addr == 8'd0)
        else $error("address without request");
    a_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_value_valid |-> m_value_data == 64'd0)
        else $error("value data without value");
endmodule

bind sensor_poll_master_fsm spm_checker u_spm_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_state_now,
    .m_send_req, .m_req_addr, .m_value_valid, .m_value_data
);
